>>> src/ttce_pkg.sv
package ttce_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int TAB_STOP       = 4;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CNT_W  = $clog2(TAB_STOP + 1);

    localparam int OUT_FIELDS_W = ROW_W + COL_W + CHAR_W + CHAR_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

    localparam logic [CHAR_W-1:0] TEXT_COLOR_RESET = 8'd7;

endpackage

>>> src/text_terminal_cursor_engine.sv
// A character is accepted in S_IDLE; its first cell write enters the output register from
// S_EMIT once the output is free, and a backspace that climbs to the row above first passes
// S_READ for the line-end memory read. One cell write per cycle while the output is not held
// off: a tab writes up to TAB_STOP cells, a printable character one, a backspace none or one
// and a newline none; no new character is taken before the last is done. Reset clears the cursor,
// the output valid flag and the per-row valid bits that mark every line end as zero.
module text_terminal_cursor_engine
    import ttce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  text_color_we,
    input  logic [CHAR_W-1:0]     text_color_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,   // char_code
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // cell_row, cell_column, cell_char, cell_color
    output logic                  m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [COL_W-1:0]         col_reg, col_next;
    logic [CHAR_W-1:0]        char_reg, char_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     bs_reg, bs_next;
    logic [CHAR_W-1:0]        color_reg, color_next;
    logic [SCREEN_ROWS-1:0]   valid_reg, valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]         out_row_reg, out_row_next;
    logic [COL_W-1:0]         out_col_reg, out_col_next;
    logic [CHAR_W-1:0]        out_char_reg, out_char_next;
    logic [CHAR_W-1:0]        out_color_reg, out_color_next;
    logic                     out_last_reg, out_last_next;

    logic [COL_W-1:0]         row_end_mem [SCREEN_ROWS];
    logic [COL_W-1:0]         row_end_rd_reg;
    logic                     mem_we;
    logic [ROW_W-1:0]         mem_waddr;
    logic [COL_W-1:0]         mem_wdata;
    logic [ROW_W-1:0]         mem_raddr;

    logic                     out_free;
    logic [ROW_W-1:0]         row_succ;
    logic [COL_W-1:0]         line_end;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign row_succ = (row_reg == ROW_W'(SCREEN_ROWS - 1)) ? '0 : row_reg + 1'b1;
    assign line_end = !valid_reg[row_reg] ? '0 :
                      (row_end_rd_reg > COL_W'(SCREEN_COLUMNS)) ? COL_W'(SCREEN_COLUMNS) :
                      row_end_rd_reg;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        char_next      = char_reg;
        cnt_next       = cnt_reg;
        bs_next        = bs_reg;
        color_next     = text_color_we ? text_color_wdata : color_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_char_next  = out_char_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = row_reg;
        mem_wdata      = col_reg;
        mem_raddr      = row_reg - 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    bs_next  = 1'b0;
                    cnt_next = CNT_W'(1);
                    if (s_axis_tdata == CODE_TAB)
                    begin
                        char_next  = CODE_SPACE;
                        cnt_next   = CNT_W'(TAB_STOP) - CNT_W'(col_reg % TAB_STOP);
                        state_next = S_EMIT;
                    end
                    else if (s_axis_tdata == CODE_NEWLINE)
                    begin
                        mem_we               = 1'b1;
                        valid_next[row_reg]  = 1'b1;
                        valid_next[row_succ] = 1'b0;
                        row_next             = row_succ;
                        col_next             = '0;
                    end
                    else if (s_axis_tdata == CODE_BACKSPACE)
                    begin
                        char_next = CODE_SPACE;
                        bs_next   = 1'b1;
                        if (col_reg != '0)
                        begin
                            col_next   = col_reg - 1'b1;
                            state_next = S_EMIT;
                        end
                        else if (row_reg != '0)
                        begin
                            row_next   = row_reg - 1'b1;
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        char_next  = s_axis_tdata;
                        state_next = S_EMIT;
                    end
                end
            end
            S_READ:
            begin
                if (line_end == '0)
                begin
                    col_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    col_next   = line_end - 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_col_next   = col_reg;
                    out_char_next  = char_reg;
                    out_color_next = color_reg;
                    out_last_next  = (cnt_reg == CNT_W'(1));
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    if (bs_reg)
                    begin
                        mem_we              = 1'b1;
                        valid_next[row_reg] = 1'b1;
                    end
                    else if (col_reg == COL_W'(SCREEN_COLUMNS - 1))
                    begin
                        mem_we               = 1'b1;
                        mem_wdata            = COL_W'(SCREEN_COLUMNS);
                        valid_next[row_reg]  = 1'b1;
                        valid_next[row_succ] = 1'b0;
                        row_next             = row_succ;
                        col_next             = '0;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_end_mem[mem_waddr] <= mem_wdata;
        end
        row_end_rd_reg <= row_end_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            bs_reg        <= 1'b0;
            color_reg     <= TEXT_COLOR_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            bs_reg        <= bs_next;
            color_reg     <= color_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_char_reg  <= out_char_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                            out_color_reg, out_char_reg, out_col_reg, out_row_reg};

endmodule
